>>> rtl/mhf_pkg.sv
// ----------------------------------------------------------------------------
// mhf_pkg
// shared types, constants and hash helpers for the multicast hash filter
// ----------------------------------------------------------------------------
package mhf_pkg;

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 48;
    localparam int FILTER_W = 64;
    localparam int HASH_W   = 6;
    localparam int CRC_W    = 32;
    localparam int HASH_SHIFT = 26;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_PROMISC_ON  = 3'd0,
        OP_PROMISC_OFF = 3'd1,
        OP_MCAST_DEL   = 3'd2,
        OP_MCAST_ADD   = 3'd3
    } op_t;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_UNSUP = 1'b1
    } status_t;

    // one result item, carried from the control unit to the output register
    typedef struct packed {
        logic                status;
        logic [FILTER_W-1:0] filter_bits;
        logic                promiscuous;
        logic [HASH_W-1:0]   hash_index;
    } res_t;

    // run the reflected crc over the address bits, elaboration time only
    // idx selects the single set data bit, idx < 0 means all-zero data
    function automatic logic [HASH_W-1:0] crc_hash_const(input int idx,
                                                         input logic [CRC_W-1:0] preset);
        logic [CRC_W-1:0] crc;
        logic             carry;
        crc = preset;
        for (int i = 0; i < ADDR_W; i++) begin
            carry = (i == idx) ^ crc[0];
            crc   = crc >> 1;
            if (carry)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc[HASH_SHIFT +: HASH_W];
    endfunction

    // hash index to filter bit: byte 2*(h/16)+1-((h/8)%2), bit h%8
    function automatic logic [HASH_W-1:0] filter_pos(input logic [HASH_W-1:0] h);
        return {h[5:4], ~h[3], h[2:0]};
    endfunction

endpackage

>>> rtl/mhf_hash.sv
// ----------------------------------------------------------------------------
// mhf_hash
// crc-32 address hash as a fixed xor network, 6-bit index out
// ----------------------------------------------------------------------------
module mhf_hash (
    input  logic [mhf_pkg::ADDR_W-1:0] addr,
    output logic [mhf_pkg::HASH_W-1:0] hash
);
    import mhf_pkg::*;

    // the crc is linear: preset contribution plus one column per address bit
    localparam logic [HASH_W-1:0] BASE = crc_hash_const(-1, CRC_PRESET);

    logic [HASH_W-1:0] terms [ADDR_W];

    genvar gi;
    generate
        for (gi = 0; gi < ADDR_W; gi++)
        begin : g_col
            localparam logic [HASH_W-1:0] COL = crc_hash_const(gi, '0);
            assign terms[gi] = addr[gi] ? COL : '0;
        end
    endgenerate

    always_comb
    begin
        hash = BASE;
        for (int i = 0; i < ADDR_W; i++) begin
            hash = hash ^ terms[i];
        end
    end

endmodule

>>> rtl/mhf_ctrl.sv
// ----------------------------------------------------------------------------
// mhf_ctrl
// op decode, filter and promiscuous state, result assembly
// ----------------------------------------------------------------------------
module mhf_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       upd_en,
    input  logic [mhf_pkg::OP_W-1:0]   op,
    input  logic [mhf_pkg::HASH_W-1:0] hash,
    output mhf_pkg::res_t              res
);
    import mhf_pkg::*;

    logic [FILTER_W-1:0] filter_reg, filter_next;
    logic                promisc_reg, promisc_next;
    logic [FILTER_W-1:0] set_mask;

    always_comb
    begin
        set_mask = '0;
        set_mask[filter_pos(hash)] = 1'b1;
    end

    always_comb
    begin
        filter_next  = filter_reg;
        promisc_next = promisc_reg;
        res.status      = STATUS_OK;
        res.hash_index  = '0;
        unique case (op)
            OP_PROMISC_ON:  promisc_next = 1'b1;
            OP_PROMISC_OFF: promisc_next = 1'b0;
            OP_MCAST_DEL:   ;
            OP_MCAST_ADD:
            begin
                filter_next    = filter_reg | set_mask;
                res.hash_index = hash;
            end
            default:        res.status = STATUS_UNSUP;
        endcase
        res.filter_bits = filter_next;
        res.promiscuous = promisc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg  <= '0;
            promisc_reg <= 1'b0;
        end
        else if (upd_en)
        begin
            filter_reg  <= filter_next;
            promisc_reg <= promisc_next;
        end
    end

endmodule

>>> rtl/multicast_hash_filter_control.sv
// ----------------------------------------------------------------------------
// multicast_hash_filter_control
// multicast hash filter and promiscuous mode control, one result per item
// ----------------------------------------------------------------------------
// each item passes through the input register, then the result register
// throughput: one item per cycle unless out_stall holds a valid result; the crc
//   hash is a fixed xor network between the input and result registers
// reset: filter cleared, promiscuous off, both pipeline stages empty
module multicast_hash_filter_control (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mhf_pkg::OP_W-1:0]     op,
    input  logic [mhf_pkg::ADDR_W-1:0]   mcast_addr,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status,
    output logic [mhf_pkg::FILTER_W-1:0] filter_bits,
    output logic                         promiscuous,
    output logic [mhf_pkg::HASH_W-1:0]   hash_index
);
    import mhf_pkg::*;

    // input register stage
    logic              s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] addr_reg;

    // result register stage
    logic out_valid_reg, out_valid_next;
    res_t res_reg;

    logic              accept_in;
    logic              advance;
    logic [HASH_W-1:0] hash;
    res_t              res_next;

    // result stage can take a new item when empty or being drained
    assign advance   = !out_valid_reg || !out_stall;
    // input stage holds only while its item cannot move on
    assign in_stall  = s1_valid_reg && !advance;
    assign accept_in = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            op_reg   <= op;
            addr_reg <= mcast_addr;
        end
        if (advance && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    mhf_hash u_hash (
        .addr (addr_reg),
        .hash (hash)
    );

    // state commits when the item moves into the result register
    mhf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd_en (advance && s1_valid_reg),
        .op     (op_reg),
        .hash   (hash),
        .res    (res_next)
    );

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign filter_bits = res_reg.filter_bits;
    assign promiscuous = res_reg.promiscuous;
    assign hash_index  = res_reg.hash_index;

endmodule
